[rtl/sswc_pkg.sv]
// Package of the sensor sample window collector: request and result item types,
// configuration register indexes and reset values, and controller/datapath links.
// Depends on nothing; every other file of the block uses it by scoped names.
package sswc_pkg;

  // Configuration register indexes.
  localparam logic CFG_STALE_AGE_LIMIT  = 1'b0;
  localparam logic CFG_PUBLISH_INTERVAL = 1'b1;

  localparam int CFG_W = 31;

  // Register values after reset.
  localparam logic [CFG_W-1:0] STALE_AGE_RESET = 31'd250;
  localparam logic [CFG_W-1:0] INTERVAL_RESET  = 31'd100;

  // Result status codes.
  localparam logic STATUS_DATA  = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // Request type codes.
  localparam logic REQ_POLL    = 1'b0;
  localparam logic REQ_PUBLISH = 1'b1;

  // One polled request.
  typedef struct packed {
    logic        req_type;
    logic [31:0] now_tick;
    logic        sample_valid;
    logic [31:0] sensor_time;
    logic [7:0]  sample_seq;
    logic [15:0] chan_a;
    logic [15:0] chan_b;
    logic [15:0] chan_c;
    logic [15:0] chan_d;
  } in_item_t;

  // One result of a published window.
  typedef struct packed {
    logic        status;
    logic [31:0] window_number;
    logic [3:0]  window_fill;
    logic [3:0]  sample_index;
    logic [15:0] out_a;
    logic [15:0] out_b;
    logic [15:0] out_c;
    logic [15:0] out_d;
    logic        stale_mark;
    logic [3:0]  stale_total;
    logic        last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic update;
    logic schedule;
    logic prep;
    logic load_smp;
    logic load_empty;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req;
    logic held_zero;
    logic publish_due;
    logic last;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/sswc_if.sv]
// Request and result channel interfaces of the sensor sample window collector.
// Depends on sswc_pkg for the payload types.
interface sswc_in_if;
  logic               valid;
  logic               ready;
  sswc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sswc_out_if;
  logic                valid;
  logic                ready;
  sswc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/sswc_datapath.sv]
// Datapath of the sensor sample window collector: request latch, configuration,
// sample ring memory, publication schedule and the result output register.
// Depends on sswc_pkg; driven by commands from sswc_ctrl.
module sswc_datapath #(
  parameter int WINDOW_DEPTH = 15
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sswc_pkg::in_item_t           in_data,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [sswc_pkg::CFG_W-1:0]   cfg_wdata,
  input  sswc_pkg::ctrl_cmd_t          cmd,
  output sswc_pkg::dp_status_t         status,
  output logic                         out_valid,
  output sswc_pkg::out_item_t          out_data,
  input  logic                         out_ready
);

  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(WINDOW_DEPTH - 1);
  localparam logic [CNT_W-1:0] HELD_FULL = CNT_W'(WINDOW_DEPTH);
  localparam logic [CNT_W-1:0] HELD_ALMOST = CNT_W'(WINDOW_DEPTH - 1);

  // Latched request.
  logic        req_r;
  logic [31:0] now_r;
  logic        vld_r;
  logic [31:0] stime_r;
  logic [7:0]  seq_r;
  logic [63:0] smp_r;

  // Configuration registers.
  logic [sswc_pkg::CFG_W-1:0] stale_lim_r;
  logic [sswc_pkg::CFG_W-1:0] interval_r;

  // Ring bookkeeping and schedule.
  logic [PTR_W-1:0] wp_r;
  logic [CNT_W-1:0] held_r;
  logic [7:0]       prev_seq_r;
  logic             have_prev_r;
  logic [31:0]      npt_r;
  logic [31:0]      win_cnt_r;

  // Window read-out.
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] idx_r;
  logic [3:0]       acc_r;
  logic [64:0]      rdata_r;
  logic [64:0]      mem [WINDOW_DEPTH];

  logic                out_valid_r;
  sswc_pkg::out_item_t out_r;
  sswc_pkg::out_item_t empty_res;

  logic             will_store;
  logic [31:0]      age;
  logic             is_stale;
  logic             full_after;
  logic [31:0]      since;
  logic             due;
  logic [PTR_W-1:0] wp_nxt;
  logic [PTR_W-1:0] ptr_nxt;
  logic [PTR_W-1:0] rd_addr;
  logic             last_now;
  logic [3:0]       acc_nxt;

  // Decision logic on the latched request.
  assign will_store = (req_r == sswc_pkg::REQ_POLL) && vld_r &&
                      (!have_prev_r || (seq_r != prev_seq_r));
  assign age        = now_r - stime_r;
  assign is_stale   = !age[31] && (age[30:0] > stale_lim_r);
  assign full_after = (held_r == HELD_FULL) || (will_store && (held_r == HELD_ALMOST));
  assign since      = now_r - npt_r;
  assign due        = (npt_r == 32'd0) || !since[31];
  assign wp_nxt     = (wp_r == LAST_PTR) ? '0 : wp_r + PTR_W'(1);
  assign ptr_nxt    = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
  assign last_now   = (CNT_W'(idx_r) + CNT_W'(1)) == held_r;
  assign acc_nxt    = acc_r + 4'(rdata_r[64]);

  // The read address runs one sample ahead whenever a result is loaded.
  assign rd_addr = cmd.load_smp ? ptr_nxt : rd_ptr_r;

  assign status.req         = req_r;
  assign status.held_zero   = (held_r == '0);
  assign status.publish_due = full_after && due;
  assign status.last        = last_now;
  assign status.out_free    = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Result of a publish request on an empty ring: only status and last are set.
  always_comb begin
    empty_res        = '0;
    empty_res.status = sswc_pkg::STATUS_EMPTY;
    empty_res.last   = 1'b1;
  end

  // Request latch.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req_r   <= in_data.req_type;
      now_r   <= in_data.now_tick;
      vld_r   <= in_data.sample_valid;
      stime_r <= in_data.sensor_time;
      seq_r   <= in_data.sample_seq;
      smp_r   <= {in_data.chan_d, in_data.chan_c, in_data.chan_b, in_data.chan_a};
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_lim_r <= sswc_pkg::STALE_AGE_RESET;
      interval_r  <= sswc_pkg::INTERVAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sswc_pkg::CFG_STALE_AGE_LIMIT:  stale_lim_r <= cfg_wdata;
        sswc_pkg::CFG_PUBLISH_INTERVAL: interval_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Ring pointer, fill level, duplicate filter, schedule and window number.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      held_r      <= '0;
      prev_seq_r  <= '0;
      have_prev_r <= 1'b0;
      npt_r       <= '0;
      win_cnt_r   <= '0;
    end else begin
      if (cmd.update && will_store) begin
        wp_r        <= wp_nxt;
        prev_seq_r  <= seq_r;
        have_prev_r <= 1'b1;
        if (held_r != HELD_FULL) begin
          held_r <= held_r + CNT_W'(1);
        end
      end
      if (cmd.schedule) begin
        npt_r <= now_r + {1'b0, interval_r};
      end
      if (cmd.prep) begin
        win_cnt_r <= win_cnt_r + 32'd1;
      end
    end
  end

  // Sample ring: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.update && will_store) begin
      mem[wp_r] <= {is_stale, smp_r};
    end
    rdata_r <= mem[rd_addr];
  end

  // Read-out position within the window.
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      rd_ptr_r <= (held_r == HELD_FULL) ? wp_r : '0;
      idx_r    <= '0;
      acc_r    <= '0;
    end else if (cmd.load_smp) begin
      rd_ptr_r <= ptr_nxt;
      idx_r    <= idx_r + PTR_W'(1);
      acc_r    <= acc_nxt;
    end
  end

  // Result output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_smp || cmd.load_empty) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_empty) begin
      out_r <= empty_res;
    end else if (cmd.load_smp) begin
      out_r.status        <= sswc_pkg::STATUS_DATA;
      out_r.window_number <= win_cnt_r;
      out_r.window_fill   <= 4'(held_r);
      out_r.sample_index  <= 4'(idx_r);
      out_r.out_a         <= rdata_r[15:0];
      out_r.out_b         <= rdata_r[31:16];
      out_r.out_c         <= rdata_r[47:32];
      out_r.out_d         <= rdata_r[63:48];
      out_r.stale_mark    <= rdata_r[64];
      out_r.stale_total   <= last_now ? acc_nxt : 4'd0;
      out_r.last          <= last_now;
    end
  end

`ifndef SYNTH
  // The fill level never passes the ring depth.
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= HELD_FULL)
    else $error("held count above ring depth");

  // A sample is never stored while a window is being read out.
  a_no_write_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.update && (cmd.load_smp || cmd.prep)))
    else $error("ring written during window read-out");

  // A non-final result moves the window position on by one.
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_smp && !last_now) |=> (idx_r == $past(idx_r) + PTR_W'(1)))
    else $error("window position did not advance");

  // Reading out an empty ring is never requested.
  a_prep_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.prep |-> (held_r != '0))
    else $error("window read-out started with an empty ring");
`endif

endmodule

[rtl/sswc_ctrl.sv]
// Controller of the sensor sample window collector: sequences request intake,
// ring update, window read-out and the empty-publish result.
// Depends on sswc_pkg; commands sswc_datapath.
module sswc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sswc_pkg::dp_status_t  status,
  output sswc_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_PREP,
    ST_RD,
    ST_LOAD,
    ST_EMPTY
  } state_t;

  state_t state_r;

  assign in_ready = (state_r == ST_IDLE);

  // Commands follow from the state and the datapath status.
  always_comb begin
    cmd            = '0;
    cmd.latch_in   = (state_r == ST_IDLE) && in_valid;
    cmd.update     = (state_r == ST_DECIDE);
    cmd.schedule   = (state_r == ST_DECIDE) &&
                     (status.req == sswc_pkg::REQ_POLL) && status.publish_due;
    cmd.prep       = (state_r == ST_PREP);
    cmd.load_smp   = (state_r == ST_LOAD) && status.out_free;
    cmd.load_empty = (state_r == ST_EMPTY) && status.out_free;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          priority if (status.req == sswc_pkg::REQ_PUBLISH && status.held_zero) begin
            state_r <= ST_EMPTY;
          end else if (status.req == sswc_pkg::REQ_PUBLISH) begin
            state_r <= ST_PREP;
          end else if (status.publish_due) begin
            state_r <= ST_PREP;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_PREP: state_r <= ST_RD;
        ST_RD:   state_r <= ST_LOAD;
        ST_LOAD: begin
          if (status.out_free && status.last) begin
            state_r <= ST_IDLE;
          end
        end
        ST_EMPTY: begin
          if (status.out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/sensor_sample_window_collector_core.sv]
// Sensor sample window collector. A poll that publishes nothing returns to idle from the decide state.
// A publication passes the decide, prep and read states, then loads its results from the ring
// read port into the output register, one per cycle while the receiver keeps taking them.
// An empty publish request goes from the decide state to the empty state, which loads its single result.
// Synchronous active-low reset: registers return to 250 and 100, counters clear; ring unchanged.
module sensor_sample_window_collector_core #(
  parameter int WINDOW_DEPTH = 15
) (
  input  logic                       clk,
  input  logic                       rst_n,
  sswc_in_if.sink                    in_req,
  sswc_out_if.source                 out_res,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [sswc_pkg::CFG_W-1:0] cfg_wdata
);

  sswc_pkg::ctrl_cmd_t  cmd;
  sswc_pkg::dp_status_t status;
  logic                 in_ready;

  assign in_req.ready = in_ready;

  // Sequencer.
  sswc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Storage and arithmetic.
  sswc_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_req.data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_res.valid),
    .out_data  (out_res.data),
    .out_ready (out_res.ready)
  );

endmodule

[tb/sensor_sample_window_collector_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of sensor_sample_window_collector_core: directed and random requests.
// Depends on sswc_pkg, on sswc_in_if and sswc_out_if, and on the core itself.
module sensor_sample_window_collector_core_tb;

  localparam int DEPTH = 15;
  localparam int CW = sswc_pkg::CFG_W;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_EMPTY, ROW_SILENT} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    sswc_pkg::in_item_t  item;
    sswc_pkg::out_item_t want;
  } stim_row_t;

  localparam sswc_pkg::out_item_t EMPTY_RESULT = sswc_pkg::out_item_t'{
    sswc_pkg::STATUS_EMPTY, 32'd0, 4'd0, 4'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 1'b0, 4'd0, 1'b1};

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [CW-1:0] cfg_wdata;

  sswc_in_if  in_ch ();
  sswc_out_if out_ch ();

  sensor_sample_window_collector_core #(
    .WINDOW_DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_ch),
    .out_res  (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Own copy of the collector state and registers.
  logic [63:0]   ring_word [DEPTH];
  logic          ring_stale [DEPTH];
  logic [3:0]    wr_ptr;
  logic [3:0]    held;
  logic [7:0]    kept_seq;
  logic          seen_seq;
  logic [31:0]   pub_due_at;
  logic [31:0]   win_count;
  logic [CW-1:0] age_limit_q;
  logic [CW-1:0] interval_q;

  // Window results still owed by the block, oldest first.
  sswc_pkg::out_item_t window_q [$];

  int   mismatches;
  logic calm;
  int   holdoff_asked;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Appends the results of one published window, oldest sample first.
  function automatic void emit_window();
    sswc_pkg::out_item_t r;
    int                  slot;
    logic [3:0]          stale_sum;
    win_count = win_count + 32'd1;
    stale_sum = '0;
    for (int i = 0; i < held; i++) begin
      slot = (held < DEPTH) ? i : (wr_ptr + i) % DEPTH;
      stale_sum = stale_sum + ring_stale[slot];
      r = '0;
      r.status        = sswc_pkg::STATUS_DATA;
      r.window_number = win_count;
      r.window_fill   = held;
      r.sample_index  = i[3:0];
      r.out_a         = ring_word[slot][15:0];
      r.out_b         = ring_word[slot][31:16];
      r.out_c         = ring_word[slot][47:32];
      r.out_d         = ring_word[slot][63:48];
      r.stale_mark    = ring_stale[slot];
      r.last          = (i == held - 1);
      r.stale_total   = r.last ? stale_sum : 4'd0;
      window_q.push_back(r);
    end
  endfunction

  // Updates the state for one accepted request and queues the results it causes.
  function automatic void predict_request(input sswc_pkg::in_item_t it);
    logic [31:0] age;
    logic [31:0] lag;
    logic        is_stale;
    if (it.req_type == sswc_pkg::REQ_PUBLISH) begin
      if (held == 0) window_q.push_back(EMPTY_RESULT);
      else emit_window();
      return;
    end
    // Keep the sample unless it repeats the previous sequence number.
    if (it.sample_valid) begin
      age = it.now_tick - it.sensor_time;
      is_stale = $signed(age) > $signed({1'b0, age_limit_q});
      if (!seen_seq || it.sample_seq != kept_seq) begin
        ring_word[wr_ptr]  = {it.chan_d, it.chan_c, it.chan_b, it.chan_a};
        ring_stale[wr_ptr] = is_stale;
        wr_ptr = (wr_ptr == DEPTH - 1) ? 4'd0 : wr_ptr + 4'd1;
        if (held < DEPTH) held = held + 4'd1;
        kept_seq = it.sample_seq;
        seen_seq = 1'b1;
      end
    end
    // Automatic publication of a full window once the interval has run out.
    lag = it.now_tick - pub_due_at;
    if (held == DEPTH && (pub_due_at == 0 || !lag[31])) begin
      emit_window();
      pub_due_at = it.now_tick + {1'b0, interval_q};
    end
  endfunction

  function automatic sswc_pkg::in_item_t req_item(input logic req, input logic [31:0] now,
                                                  input logic valid,
                                                  input logic [31:0] stime,
                                                  input logic [7:0] seq,
                                                  input logic [15:0] a,
                                                  input logic [15:0] b,
                                                  input logic [15:0] c,
                                                  input logic [15:0] d);
    sswc_pkg::in_item_t it;
    it = '{req, now, valid, stime, seq, a, b, c, d};
    return it;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Offers one request after a random idle gap and returns at the edge that accepts it.
  task automatic send_request(input sswc_pkg::in_item_t it);
    while (!calm && $urandom_range(99) < 29) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Writes one register while the block is idle, and the predictor's copy with it.
  task automatic write_register(input logic idx, input logic [CW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sswc_pkg::CFG_STALE_AGE_LIMIT) age_limit_q = value;
    else interval_q = value;
    @(posedge clk);
  endtask

  // Result side: random back-pressure, long hold-offs on request, and checking.
  initial begin
    sswc_pkg::out_item_t want;
    int                  hold_left;
    int                  holds_served;
    out_ch.ready <= 1'b0;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (window_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %p", $time, out_ch.data);
          mismatches++;
        end else begin
          want = window_q.pop_front();
          check_field("status", want.status, out_ch.data.status);
          check_field("window_number", want.window_number, out_ch.data.window_number);
          check_field("window_fill", want.window_fill, out_ch.data.window_fill);
          check_field("sample_index", want.sample_index, out_ch.data.sample_index);
          check_field("out_a", want.out_a, out_ch.data.out_a);
          check_field("out_b", want.out_b, out_ch.data.out_b);
          check_field("out_c", want.out_c, out_ch.data.out_c);
          check_field("out_d", want.out_d, out_ch.data.out_d);
          check_field("stale_mark", want.stale_mark, out_ch.data.stale_mark);
          check_field("stale_total", want.stale_total, out_ch.data.stale_total);
          check_field("last", want.last, out_ch.data.last);
        end
      end
      if (holdoff_asked != holds_served) begin
        holds_served = holdoff_asked;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 29);
      end
    end
  end

  // Request side: reset, directed table, then random phases under several settings.
  initial begin
    stim_row_t          directed_rows [$];
    sswc_pkg::in_item_t it;
    int                 queued;
    int                 pick;
    logic [31:0]        tick;
    logic [31:0]        age;
    logic [7:0]         seq_cursor;
    logic [CW-1:0]      phase_limit [4];
    logic [CW-1:0]      phase_interval [4];

    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= sswc_pkg::CFG_STALE_AGE_LIMIT;
    cfg_wdata   <= '0;
    calm        <= 1'b0;
    holdoff_asked <= 0;
    mismatches  = 0;

    wr_ptr      = '0;
    held        = '0;
    kept_seq    = '0;
    seen_seq    = 1'b0;
    pub_due_at  = '0;
    win_count   = '0;
    age_limit_q = sswc_pkg::STALE_AGE_RESET;
    interval_q  = sswc_pkg::INTERVAL_RESET;

    // Publish on an empty window, a poll with no sample, the first sequence number
    // being zero, a repeated sequence number, ages at, above and below the limit,
    // the wrapped signed extremes of age, an early publish request, the fill that
    // publishes at once, a poll before the schedule and one exactly on it.
    directed_rows.push_back('{ROW_EMPTY, req_item(sswc_pkg::REQ_PUBLISH, 32'd1000, 1'b1,
                              32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF), EMPTY_RESULT});
    directed_rows.push_back('{ROW_SILENT, req_item(sswc_pkg::REQ_POLL, 32'd1001, 1'b0,
                              32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF), '0});
    directed_rows.push_back('{ROW_SILENT, req_item(sswc_pkg::REQ_POLL, 32'd1002, 1'b1,
                              32'd1002, 8'd0, 16'h0000, 16'h0000, 16'h0000,
                              16'h0000), '0});
    directed_rows.push_back('{ROW_SILENT, req_item(sswc_pkg::REQ_POLL, 32'd1003, 1'b1,
                              32'd1003, 8'd0, 16'h1234, 16'h5678, 16'h9ABC,
                              16'hDEF0), '0});
    directed_rows.push_back('{ROW_PREDICT, req_item(sswc_pkg::REQ_POLL, 32'd1004, 1'b1,
                              32'd754, 8'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF), '0});
    directed_rows.push_back('{ROW_PREDICT, req_item(sswc_pkg::REQ_POLL, 32'd1005, 1'b1,
                              32'd754, 8'd2, 16'hA5A5, 16'h5A5A, 16'h0001,
                              16'h8000), '0});
    directed_rows.push_back('{ROW_PREDICT, req_item(sswc_pkg::REQ_POLL, 32'd1006, 1'b1,
                              32'd5000, 8'd3, 16'h8000, 16'h0001, 16'h5A5A,
                              16'hA5A5), '0});
    directed_rows.push_back('{ROW_PREDICT, req_item(sswc_pkg::REQ_POLL, 32'd1008, 1'b1,
                              32'h8000_03F0, 8'd4, 16'h0F0F, 16'hF0F0, 16'h00FF,
                              16'hFF00), '0});
    directed_rows.push_back('{ROW_PREDICT, req_item(sswc_pkg::REQ_POLL, 32'd1009, 1'b1,
                              32'h8000_03F2, 8'd5, 16'hFF00, 16'h00FF, 16'hF0F0,
                              16'h0F0F), '0});
    directed_rows.push_back('{ROW_PREDICT, req_item(sswc_pkg::REQ_PUBLISH, 32'd1009, 1'b0,
                              32'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0), '0});
    for (int k = 0; k < 9; k++) begin
      directed_rows.push_back('{ROW_PREDICT, req_item(sswc_pkg::REQ_POLL, 32'd1010 + k,
                                1'b1, 32'd1000 + k, 8'(6 + k), 16'(16'h1111 * k),
                                16'(16'h0101 + k), 16'(16'hFFF0 - k),
                                16'(16'h7FFF + k)), '0});
    end
    directed_rows.push_back('{ROW_PREDICT, req_item(sswc_pkg::REQ_POLL, 32'd1019, 1'b0,
                              32'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0), '0});
    directed_rows.push_back('{ROW_PREDICT, req_item(sswc_pkg::REQ_POLL, 32'd1118, 1'b1,
                              32'd1117, 8'd15, 16'hCAFE, 16'hBEEF, 16'h0BAD,
                              16'hF00D), '0});
    directed_rows.push_back('{ROW_PREDICT, req_item(sswc_pkg::REQ_PUBLISH, 32'd1119, 1'b0,
                              32'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0), '0});

    phase_limit[0]    = '0;
    phase_interval[0] = '0;
    phase_limit[1]    = 31'h7FFF_FFFF;
    phase_interval[1] = 31'h7FFF_FFFF;
    phase_limit[2]    = CW'($urandom_range(400));
    phase_interval[2] = CW'($urandom_range(200));
    phase_limit[3]    = CW'($urandom());
    phase_interval[3] = CW'($urandom_range(120));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table under the reset register values.
    foreach (directed_rows[k]) begin
      send_request(directed_rows[k].item);
      queued = window_q.size();
      predict_request(directed_rows[k].item);
      if (directed_rows[k].kind != ROW_PREDICT) begin
        while (window_q.size() > queued) void'(window_q.pop_back());
        if (directed_rows[k].kind == ROW_EMPTY) window_q.push_back(directed_rows[k].want);
      end
    end
    in_ch.valid <= 1'b0;

    tick = 32'd1200;
    seq_cursor = 8'd16;
    for (int ph = 0; ph < 4; ph++) begin
      // Let the block drain and go idle before touching the registers.
      while (window_q.size() != 0) @(posedge clk);
      repeat (20) @(posedge clk);
      write_register(sswc_pkg::CFG_STALE_AGE_LIMIT, phase_limit[ph]);
      write_register(sswc_pkg::CFG_PUBLISH_INTERVAL, phase_interval[ph]);

      for (int n = 0; n < 50; n++) begin
        // Sender pause until the block has delivered everything.
        if (ph == 1 && n == 20) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (window_q.size() != 0) @(posedge clk);
        end
        // Long receiver hold-off while requests keep coming.
        if (ph == 2 && n == 10) holdoff_asked <= holdoff_asked + 1;
        if (ph == 3) calm <= (n < 40);

        // Tick: mostly small steps, sometimes a jump or the value that schedules zero.
        pick = $urandom_range(99);
        if (pick < 5) tick = $urandom();
        else if (pick < 8) tick = 32'd0 - {1'b0, interval_q};
        else tick = tick + $urandom_range(1, 40);

        pick = $urandom_range(99);
        if (pick < 45) age = $urandom_range(0, 300);
        else if (pick < 70) age = {1'b0, age_limit_q} + $urandom_range(0, 2) - 1;
        else age = $urandom();

        pick = $urandom_range(99);
        if (pick < 5) seq_cursor = 8'($urandom_range(255));
        else if (pick >= 20) seq_cursor = seq_cursor + 8'd1;

        it.req_type     = ($urandom_range(99) < 8) ? sswc_pkg::REQ_PUBLISH
                                                   : sswc_pkg::REQ_POLL;
        it.now_tick     = tick;
        it.sample_valid = ($urandom_range(99) < 85);
        it.sensor_time  = tick - age;
        it.sample_seq   = seq_cursor;
        it.chan_a       = 16'($urandom());
        it.chan_b       = 16'($urandom());
        it.chan_c       = 16'($urandom());
        it.chan_d       = 16'($urandom());

        send_request(it);
        predict_request(it);
      end
      in_ch.valid <= 1'b0;
    end

    // Drain, then allow for the block's latency before the verdict.
    while (window_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && window_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
